[rtl/slt_pkg.sv]
`default_nettype none

package slt_pkg;

    localparam int LIST_DEPTH = 8;

    // Index and count widths follow from the depth.
    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    // Fixed field widths of the request and result.
    localparam int CMD_W   = 2;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 3;
    localparam int COUNT_W = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SEARCH = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UP,
        ST_DOWN,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

[rtl/slt_if.sv]
`default_nettype none

interface slt_req_if
    import slt_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           command;
    logic signed [VALUE_W-1:0]  item_value;

    modport source (output valid, output command, output item_value, input ready);
    modport sink   (input valid, input command, input item_value, output ready);
endinterface

interface slt_res_if
    import slt_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               success;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] entry_count;
    logic               is_full;

    modport source (output valid, output success, output position, output entry_count,
                    output is_full, input ready);
    modport sink   (input valid, input success, input position, input entry_count,
                    input is_full, output ready);
endinterface

`default_nettype wire

[rtl/sorted_list_table_top.sv]
// An accepted request first scans the list from slot 0. An insert then shifts the entries
// above its slot up by one from the end, and a remove shifts those above the match down;
// a search, a miss, an insert into a full list and the unused code go straight to the result.
// Throughput: one request at a time; the next is accepted in the cycle after the result is
// loaded, and a result is loaded only once the previous one has been taken.
// Reset clears the entry count, the sequencer and the result valid flag; entries are not reset.
`default_nettype none

module sorted_list_table_top
    import slt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    slt_req_if.sink    request,
    slt_res_if.source  result
);

    state_t                     state_reg, state_next;
    logic [CMD_W-1:0]           cmd_reg, cmd_next;
    logic signed [VALUE_W-1:0]  value_reg, value_next;
    logic [CNT_W-1:0]           idx_reg, idx_next;
    logic [IDX_W-1:0]           pos_reg, pos_next;
    logic                       ok_reg, ok_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       out_load;

    logic                       out_success_reg;
    logic [POS_W-1:0]           out_position_reg;
    logic [COUNT_W-1:0]         out_count_reg;
    logic                       out_full_reg;

    logic signed [VALUE_W-1:0]  entry_reg [LIST_DEPTH];

    logic [CNT_W-1:0]           idx_inc;
    logic [CNT_W-1:0]           idx_dec;
    logic [IDX_W-1:0]           rd_idx;
    logic signed [VALUE_W-1:0]  rd_data;
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_idx;
    logic signed [VALUE_W-1:0]  wr_data;
    logic                       list_full;

    assign idx_inc   = idx_reg + CNT_W'(1);
    assign idx_dec   = idx_reg - CNT_W'(1);
    assign list_full = (count_reg == CNT_W'(LIST_DEPTH));

    // The shift passes read the neighbour of the slot being written.
    always_comb
    begin
        case (state_reg)
            ST_UP:   rd_idx = idx_dec[IDX_W-1:0];
            ST_DOWN: rd_idx = idx_inc[IDX_W-1:0];
            default: rd_idx = idx_reg[IDX_W-1:0];
        endcase
    end

    assign rd_data = entry_reg[rd_idx];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            cmd_reg       <= '0;
            idx_reg       <= '0;
            pos_reg       <= '0;
            ok_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            cmd_reg       <= cmd_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            ok_reg        <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        if (out_load)
        begin
            out_success_reg  <= ok_reg;
            out_position_reg <= ok_reg ? POS_W'(pos_reg) : '0;
            out_count_reg    <= COUNT_W'(count_reg);
            out_full_reg     <= list_full;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        value_next     = value_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        ok_next        = ok_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_load       = 1'b0;
        wr_en          = 1'b0;
        wr_idx         = idx_reg[IDX_W-1:0];
        wr_data        = rd_data;
        request.ready  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                request.ready = 1'b1;
                if (request.valid)
                begin
                    cmd_next   = request.command;
                    value_next = request.item_value;
                    idx_next   = '0;
                    pos_next   = '0;
                    ok_next    = 1'b0;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (list_full)
                        begin
                            state_next = ST_RESP;
                        end
                        else if (idx_reg == count_reg || rd_data > value_reg)
                        begin
                            pos_next   = idx_reg[IDX_W-1:0];
                            idx_next   = count_reg;
                            state_next = ST_UP;
                        end
                        else
                        begin
                            idx_next = idx_inc;
                        end
                    end

                    CMD_REMOVE, CMD_SEARCH:
                    begin
                        if (idx_reg == count_reg)
                        begin
                            state_next = ST_RESP;
                        end
                        else if (rd_data == value_reg)
                        begin
                            pos_next = idx_reg[IDX_W-1:0];
                            if (cmd_reg == CMD_SEARCH)
                            begin
                                ok_next    = 1'b1;
                                state_next = ST_RESP;
                            end
                            else
                            begin
                                state_next = ST_DOWN;
                            end
                        end
                        else
                        begin
                            idx_next = idx_inc;
                        end
                    end

                    default:
                    begin
                        state_next = ST_RESP;
                    end
                endcase
            end

            ST_UP:
            begin
                wr_en = 1'b1;
                if (idx_reg == CNT_W'(pos_reg))
                begin
                    wr_data    = value_reg;
                    count_next = count_reg + CNT_W'(1);
                    ok_next    = 1'b1;
                    state_next = ST_RESP;
                end
                else
                begin
                    idx_next = idx_dec;
                end
            end

            ST_DOWN:
            begin
                if (idx_inc >= count_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    ok_next    = 1'b1;
                    state_next = ST_RESP;
                end
                else
                begin
                    wr_en    = 1'b1;
                    idx_next = idx_inc;
                end
            end

            ST_RESP:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result.valid       = out_valid_reg;
    assign result.success     = out_success_reg;
    assign result.position    = out_position_reg;
    assign result.entry_count = out_count_reg;
    assign result.is_full     = out_full_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LIST_DEPTH))
        else $error("entry count exceeds list depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready) |=> state_reg == ST_SCAN)
        else $error("accepted request did not start a scan");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ($past(state_reg) == ST_UP || $past(state_reg) == ST_DOWN))
        else $error("entry count changed outside a shift pass");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.success) |-> result.position == '0)
        else $error("failed request reported a nonzero position");

endmodule

`default_nettype wire

[bench/tb_top.sv]
`default_nettype none

module tb_top
    import slt_pkg::*;
;

    // The unused command code is not a member of cmd_t, so it gets a name here.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam bit TYPED = 1'b1;
    localparam bit PREDICTED = 1'b0;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic               success;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] entry_count;
        logic               is_full;
    } outcome_t;

    typedef struct packed {
        logic [CMD_W-1:0]          op;
        logic signed [VALUE_W-1:0] val;
        bit                        typed;
        outcome_t                  want;
    } plan_row_t;

    localparam outcome_t NONE = '0;

    logic clk;
    logic rst_n;

    slt_req_if req_ch ();
    slt_res_if res_ch ();

    sorted_list_table_top dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .request(req_ch),
        .result (res_ch)
    );

    // Shadow copy of the sorted list.
    logic signed [VALUE_W-1:0] list_vals [LIST_DEPTH];
    int                        list_len;

    outcome_t pending_outcomes [$];
    int       mismatch_count;
    int       send_idle_pct;
    int       recv_stall_pct;

    // Walk of the list from empty to full and back, with the extremes of the value range,
    // equal values, a rejected insert, misses and the unused command code.
    plan_row_t plan [25] = '{
        '{CMD_SEARCH, 32'sd0,        TYPED,     '{1'b0, 3'd0, 4'd0, 1'b0}},
        '{CMD_REMOVE, 32'sd0,        TYPED,     '{1'b0, 3'd0, 4'd0, 1'b0}},
        '{CMD_UNUSED, 32'sd5,        TYPED,     '{1'b0, 3'd0, 4'd0, 1'b0}},
        '{CMD_INSERT, VAL_MAX,       TYPED,     '{1'b1, 3'd0, 4'd1, 1'b0}},
        '{CMD_INSERT, VAL_MIN,       TYPED,     '{1'b1, 3'd0, 4'd2, 1'b0}},
        '{CMD_INSERT, 32'sd0,        TYPED,     '{1'b1, 3'd1, 4'd3, 1'b0}},
        '{CMD_INSERT, 32'sd0,        TYPED,     '{1'b1, 3'd2, 4'd4, 1'b0}},
        '{CMD_INSERT, -32'sd1,       PREDICTED, NONE},
        '{CMD_INSERT, 32'sh5555_5555, PREDICTED, NONE},
        '{CMD_INSERT, 32'shAAAA_AAAA, PREDICTED, NONE},
        '{CMD_INSERT, VAL_MAX,       PREDICTED, NONE},
        '{CMD_INSERT, 32'sd1,        TYPED,     '{1'b0, 3'd0, 4'd8, 1'b1}},
        '{CMD_SEARCH, 32'sd0,        PREDICTED, NONE},
        '{CMD_SEARCH, 32'sd12345,    TYPED,     '{1'b0, 3'd0, 4'd8, 1'b1}},
        '{CMD_REMOVE, VAL_MAX,       PREDICTED, NONE},
        '{CMD_UNUSED, -32'sd7,       TYPED,     '{1'b0, 3'd0, 4'd7, 1'b0}},
        '{CMD_REMOVE, 32'sd0,        PREDICTED, NONE},
        '{CMD_REMOVE, 32'sd99,       TYPED,     '{1'b0, 3'd0, 4'd6, 1'b0}},
        '{CMD_REMOVE, VAL_MIN,       PREDICTED, NONE},
        '{CMD_SEARCH, VAL_MAX,       PREDICTED, NONE},
        '{CMD_REMOVE, 32'shAAAA_AAAA, PREDICTED, NONE},
        '{CMD_REMOVE, -32'sd1,       PREDICTED, NONE},
        '{CMD_REMOVE, 32'sd0,        PREDICTED, NONE},
        '{CMD_REMOVE, 32'sh5555_5555, PREDICTED, NONE},
        '{CMD_REMOVE, VAL_MAX,       PREDICTED, NONE}
    };

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic bit find_slot(input logic signed [VALUE_W-1:0] val, output int slot);
        slot = 0;
        for (int i = 0; i < list_len; i++)
        begin
            if (list_vals[i] == val)
            begin
                slot = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Applies one request to the shadow list and returns the result it should give.
    function automatic outcome_t apply_op(input logic [CMD_W-1:0] op,
                                          input logic signed [VALUE_W-1:0] val);
        outcome_t o;
        int       slot;
        bit       hit;
        o = '0;
        slot = 0;
        hit = 1'b0;
        case (op)
            CMD_INSERT:
            begin
                if (list_len < LIST_DEPTH)
                begin
                    // Equal values stay in arrival order: stop at the first greater entry.
                    while (slot < list_len && list_vals[slot] <= val)
                        slot++;
                    for (int i = list_len; i > slot; i--)
                        list_vals[i] = list_vals[i-1];
                    list_vals[slot] = val;
                    list_len++;
                    hit = 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                hit = find_slot(val, slot);
                if (hit)
                begin
                    for (int i = slot; i + 1 < list_len; i++)
                        list_vals[i] = list_vals[i+1];
                    list_len--;
                end
            end
            CMD_SEARCH:
                hit = find_slot(val, slot);
            default:
                hit = 1'b0;
        endcase
        o.success     = hit;
        o.position    = hit ? slot[POS_W-1:0] : '0;
        o.entry_count = list_len[COUNT_W-1:0];
        o.is_full     = (list_len == LIST_DEPTH);
        return o;
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_request(input logic [CMD_W-1:0] op,
                                input logic signed [VALUE_W-1:0] val,
                                input bit typed, input outcome_t want);
        outcome_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.command    <= op;
        req_ch.item_value <= val;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = apply_op(op, val);
        pending_outcomes.push_back(typed ? want : predicted);
    endtask

    task automatic random_request(input int insert_pct);
        logic [CMD_W-1:0]          op;
        logic signed [VALUE_W-1:0] val;
        int                        pick;
        pick = $urandom_range(99);
        if (pick < insert_pct)
            op = CMD_INSERT;
        else if (pick < 95)
            op = $urandom_range(1) ? CMD_REMOVE : CMD_SEARCH;
        else
            op = CMD_UNUSED;
        // Half the time a value already stored, so that removes and searches hit and duplicates
        // pile up; the rest from a small pool with the extremes, or fully random.
        pick = $urandom_range(9);
        if (pick < 5 && list_len > 0)
            val = list_vals[$urandom_range(list_len - 1)];
        else if (pick < 8)
        begin
            case ($urandom_range(3))
                0: val = VAL_MIN;
                1: val = VAL_MAX;
                default: val = int'($urandom_range(6)) - 3;
            endcase
        end
        else
            val = $urandom;
        send_request(op, val, PREDICTED, NONE);
    endtask

    initial
    begin
        outcome_t want;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                if (pending_outcomes.size() == 0)
                    flag_mismatch("result with no request pending", 0, 0);
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (res_ch.success !== want.success)
                        flag_mismatch("success", res_ch.success, want.success);
                    if (res_ch.position !== want.position)
                        flag_mismatch("position", res_ch.position, want.position);
                    if (res_ch.entry_count !== want.entry_count)
                        flag_mismatch("entry_count", res_ch.entry_count, want.entry_count);
                    if (res_ch.is_full !== want.is_full)
                        flag_mismatch("is_full", res_ch.is_full, want.is_full);
                end
            end
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.command    = CMD_INSERT;
        req_ch.item_value = '0;
        res_ch.ready      = 1'b0;
        list_len          = 0;
        mismatch_count    = 0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        foreach (list_vals[i])
            list_vals[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_request(plan[i].op, plan[i].val, plan[i].typed, plan[i].want);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            // Alternate fill-heavy and drain-heavy stretches so the list keeps crossing
            // between empty and full.
            for (int n = 0; n < 300; n++)
                random_request(((n / 50) % 2 == 0) ? 65 : 20);
        end
        req_ch.valid <= 1'b0;

        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
